>>> rtl/slb_pkg.sv
// Shared types, constants and codes of the segment load balancer.
`timescale 1ns / 1ps
package slb_pkg;

   localparam int SEGMENTS_DEF     = 16;
   localparam int WORKERS_DEF      = 32;
   localparam int MAX_CHANGES      = 16;
   localparam int ADDR_W           = 48;
   localparam int SLOT_W           = 6;
   localparam int SEG_W            = 5;
   localparam int CNT_W            = 5;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 6;
   localparam int WLIM_W           = 6;
   localparam logic [SEG_W-1:0]  SEG_COUNT_RST    = 5'd16;
   localparam logic [WLIM_W-1:0] WORKER_LIMIT_RST = 6'd30;

   localparam logic [CSR_IDX_W-1:0] CSR_SEG_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORKER_LIMIT = 1'b1;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_SOLVED = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_SLOT   = 2'd1;
   localparam logic [1:0] ST_UNKNOWN   = 2'd2;
   localparam logic [1:0] ST_NOT_OWNED = 2'd3;

   localparam logic KIND_CHANGE = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_ADD_SCAN, S_ADD_DEC,
      S_BAL1_W, S_BAL1_S, S_BAL1_G,
      S_BAL2_W, S_BAL2_S, S_BAL2_G,
      S_END, S_REL, S_STATUS
   } slb_state_type;

   typedef struct packed {
      logic       load_req;
      logic       w_clr;
      logic       w_step;
      logic       s_clr_hi;
      logic       s_clr_lo;
      logic       s_down;
      logic       s_up;
      logic       add_scan;
      logic       lh_scan;
      logic       seg_scan1;
      logic       seg_scan2;
      logic       do_add;
      logic       do_remove;
      logic       do_solved;
      logic       give1;
      logic       give2;
      logic       do_release;
      logic       emit_status;
      logic [1:0] code;
   } slb_cmd_type;

   typedef struct packed {
      logic       out_free;
      logic       w_end;
      logic       w_last;
      logic       s_first;
      logic       s_last;
      logic [1:0] req_type;
      logic       slot_ok;
      logic       seg_owned;
      logic       match_found;
      logic       free_found;
      logic       lo_valid;
      logic       spread;
      logic       seg_found;
      logic       cap;
      logic       rel_hit;
   } slb_stat_type;

endpackage

>>> rtl/slb_req_if.sv
// Request channel: valid/ready handshake with the request fields.
`timescale 1ns / 1ps
interface slb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [47:0] worker_addr;
   logic [5:0]  worker_slot;
   logic [4:0]  segment_number;
   modport source (output valid, req_type, worker_addr, worker_slot, segment_number,
                   input ready);
   modport sink   (input valid, req_type, worker_addr, worker_slot, segment_number,
                   output ready);
endinterface

>>> rtl/slb_rsp_if.sv
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps
interface slb_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [1:0] status_code;
   logic [5:0] slot_out;
   logic [4:0] segment_out;
   logic       last_item;
   modport source (output valid, item_kind, status_code, slot_out, segment_out, last_item,
                   input ready);
   modport sink   (input valid, item_kind, status_code, slot_out, segment_out, last_item,
                   output ready);
endinterface

>>> rtl/segment_load_balancer_core.sv
// Top level of the segment load balancer: controller, datapath and assertions.
// Sequence: a solved report or a rejected remove goes from dispatch straight to its status;
// an add first scans the address store, then decides.
// Each balancing step is a load scan over the workers, then a segment scan;
// up to 16 steps per request plus one step that ends each phase; a remove adds a release scan.
// One transaction at a time; the next is accepted once the status is in the result register.
// Synchronous reset clears all tables except the address store; no clearing pass is needed.
`timescale 1ns / 1ps
module segment_load_balancer_core
   import slb_pkg::*;
#(
   parameter int SEGMENTS = SEGMENTS_DEF,
   parameter int WORKERS  = WORKERS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   slb_req_if.sink               req_ch,
   slb_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   slb_cmd_type  cmd;
   slb_stat_type stat;

   slb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   slb_dp #(
      .SEGMENTS (SEGMENTS),
      .WORKERS  (WORKERS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_type       (req_ch.req_type),
      .worker_addr    (req_ch.worker_addr),
      .worker_slot    (req_ch.worker_slot),
      .segment_number (req_ch.segment_number),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .item_kind      (rsp_ch.item_kind),
      .status_code    (rsp_ch.status_code),
      .slot_out       (rsp_ch.slot_out),
      .segment_out    (rsp_ch.segment_out),
      .last_item      (rsp_ch.last_item),
      .cmd            (cmd),
      .stat           (stat)
   );

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.give1 || cmd.give2 || cmd.do_release || cmd.emit_status) |-> stat.out_free)
      else $error("result loaded into occupied register");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_status |=> rsp_ch.valid && rsp_ch.last_item)
      else $error("status transaction not presented as last");

   a_change_cap: assert property (@(posedge clock) disable iff (reset)
      (cmd.give1 || cmd.give2 || cmd.do_release) |-> !stat.cap)
      else $error("owner change beyond cap");

endmodule

>>> rtl/slb_ctrl.sv
// Sequencing state machine of the segment load balancer.
`timescale 1ns / 1ps
module slb_ctrl
   import slb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  slb_stat_type stat,
   output slb_cmd_type  cmd
);

   slb_state_type state_ff, state_in;
   logic [1:0]    code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            code_in  = ST_OK;
            state_in = S_STATUS;
            unique case (stat.req_type)
               REQ_ADD:    state_in = S_ADD_SCAN;
               REQ_REMOVE: begin
                  if (stat.slot_ok) state_in = S_BAL1_W;
                  else code_in = ST_UNKNOWN;
               end
               REQ_SOLVED: begin
                  if (!stat.slot_ok) code_in = ST_UNKNOWN;
                  else if (!stat.seg_owned) code_in = ST_NOT_OWNED;
               end
               default: code_in = ST_OK;
            endcase
         end
         S_ADD_SCAN: begin
            if (stat.w_end) state_in = S_ADD_DEC;
         end
         S_ADD_DEC: begin
            priority if (stat.match_found) state_in = S_STATUS;
            else if (!stat.free_found) begin
               code_in  = ST_NO_SLOT;
               state_in = S_STATUS;
            end else state_in = S_BAL1_W;
         end
         S_BAL1_W: if (stat.w_last) state_in = S_BAL1_S;
         S_BAL1_S: if (stat.s_first) state_in = S_BAL1_G;
         S_BAL1_G: begin
            priority if (stat.cap || !stat.lo_valid || !stat.seg_found) state_in = S_BAL2_W;
            else if (stat.out_free) state_in = S_BAL1_W;
            else state_in = S_BAL1_G;
         end
         S_BAL2_W: if (stat.w_last) state_in = S_BAL2_S;
         S_BAL2_S: if (stat.s_first) state_in = S_BAL2_G;
         S_BAL2_G: begin
            priority if (stat.cap || !stat.lo_valid || !stat.spread || !stat.seg_found)
               state_in = S_END;
            else if (stat.out_free) state_in = S_BAL2_W;
            else state_in = S_BAL2_G;
         end
         S_END: begin
            state_in = (stat.req_type == REQ_REMOVE) ? S_REL : S_STATUS;
         end
         S_REL: begin
            priority if (stat.rel_hit && !stat.cap && !stat.out_free) state_in = S_REL;
            else if (stat.s_last) state_in = S_STATUS;
            else state_in = S_REL;
         end
         S_STATUS: if (stat.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.code  = code_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_DISPATCH: begin
            cmd.w_clr = 1'b1;
            if (stat.req_type == REQ_REMOVE && stat.slot_ok) cmd.do_remove = 1'b1;
            if (stat.req_type == REQ_SOLVED && stat.slot_ok && stat.seg_owned)
               cmd.do_solved = 1'b1;
         end
         S_ADD_SCAN: begin
            cmd.add_scan = 1'b1;
            cmd.w_step   = 1'b1;
         end
         S_ADD_DEC: begin
            cmd.w_clr = 1'b1;
            if (!stat.match_found && stat.free_found) cmd.do_add = 1'b1;
         end
         S_BAL1_W, S_BAL2_W: begin
            cmd.lh_scan  = 1'b1;
            cmd.w_step   = 1'b1;
            cmd.s_clr_hi = stat.w_last;
         end
         S_BAL1_S: begin
            cmd.seg_scan1 = 1'b1;
            cmd.s_down    = 1'b1;
         end
         S_BAL2_S: begin
            cmd.seg_scan2 = 1'b1;
            cmd.s_down    = 1'b1;
         end
         S_BAL1_G: begin
            cmd.w_clr = 1'b1;
            if (!(stat.cap || !stat.lo_valid || !stat.seg_found) && stat.out_free)
               cmd.give1 = 1'b1;
         end
         S_BAL2_G: begin
            cmd.w_clr = 1'b1;
            if (!(stat.cap || !stat.lo_valid || !stat.spread || !stat.seg_found)
                && stat.out_free)
               cmd.give2 = 1'b1;
         end
         S_END: cmd.s_clr_lo = 1'b1;
         S_REL: begin
            if (stat.rel_hit && !stat.cap) begin
               cmd.do_release = stat.out_free;
               cmd.s_up       = stat.out_free;
            end else cmd.s_up = 1'b1;
         end
         S_STATUS: cmd.emit_status = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> rtl/slb_dp.sv
// Datapath: segment and slot tables, scan counters and result register.
`timescale 1ns / 1ps
module slb_dp
   import slb_pkg::*;
#(
   parameter int SEGMENTS = SEGMENTS_DEF,
   parameter int WORKERS  = WORKERS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [1:0]            req_type,
   input  logic [ADDR_W-1:0]     worker_addr,
   input  logic [SLOT_W-1:0]     worker_slot,
   input  logic [SEG_W-1:0]      segment_number,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  item_kind,
   output logic [1:0]            status_code,
   output logic [SLOT_W-1:0]     slot_out,
   output logic [SEG_W-1:0]      segment_out,
   output logic                  last_item,
   input  slb_cmd_type           cmd,
   output slb_stat_type          stat
);

   localparam int WIDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int WCNT_W = $clog2(WORKERS + 1);
   localparam int SIDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
   localparam int LOAD_W = $clog2(SEGMENTS + 1);

   logic [1:0]         req_type_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SEG_W-1:0]   segn_ff;
   logic [SEG_W-1:0]   seg_count_ff;
   logic [WLIM_W-1:0]  worker_limit_ff;

   logic [SLOT_W-1:0]  owner_ff    [SEGMENTS];
   logic               done_ff     [SEGMENTS];
   logic               released_ff [SEGMENTS];
   logic               active_ff   [WORKERS];
   logic [LOAD_W-1:0]  load_ff     [WORKERS];
   logic [ADDR_W-1:0]  addr_mem    [WORKERS];

   logic [ADDR_W-1:0]  rd_ff;
   logic [WIDX_W-1:0]  rd_idx_ff;
   logic               rd_vld_ff;

   logic [WCNT_W-1:0]  wcnt_ff, wcnt_in;
   logic [SIDX_W-1:0]  scnt_ff, scnt_in;
   logic [CNT_W-1:0]   n_ff, n_in;

   logic               match_ff, free_found_ff;
   logic [WIDX_W-1:0]  free_idx_ff;
   logic [SLOT_W-1:0]  stat_slot_ff;
   logic               lo_v_ff;
   logic [WIDX_W-1:0]  lo_ff, hi_ff;
   logic [LOAD_W-1:0]  minv_ff, maxv_ff;
   logic               seg_found_ff;
   logic [SIDX_W-1:0]  seg_sel_ff;

   logic               out_valid_ff;
   logic               kind_ff, last_ff;
   logic [1:0]         code_ff;
   logic [SLOT_W-1:0]  oslot_ff;
   logic [SEG_W-1:0]   oseg_ff;

   logic [WIDX_W-1:0]  widx, slot_idx;
   logic [SIDX_W-1:0]  segn_idx;
   logic [SLOT_W-1:0]  lo_slot, hi_slot;
   logic               out_free, emit, in_scan_w;

   assign widx     = wcnt_ff[WIDX_W-1:0];
   assign slot_idx = WIDX_W'(int'(slot_ff) - 1);
   assign segn_idx = SIDX_W'(int'(segn_ff) - 1);
   assign lo_slot  = SLOT_W'(lo_ff) + SLOT_W'(1);
   assign hi_slot  = SLOT_W'(hi_ff) + SLOT_W'(1);
   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = cmd.give1 || cmd.give2 || cmd.do_release || cmd.emit_status;
   assign in_scan_w = int'(wcnt_ff) < WORKERS;

   always_comb begin
      stat.out_free    = out_free;
      stat.w_end       = int'(wcnt_ff) == WORKERS;
      stat.w_last      = int'(wcnt_ff) == WORKERS - 1;
      stat.s_first     = scnt_ff == '0;
      stat.s_last      = int'(scnt_ff) == SEGMENTS - 1;
      stat.req_type    = req_type_ff;
      stat.slot_ok     = slot_ff != '0 && int'(slot_ff) <= WORKERS && active_ff[slot_idx];
      stat.seg_owned   = segn_ff != '0 && int'(segn_ff) <= SEGMENTS
                         && owner_ff[segn_idx] == slot_ff;
      stat.match_found = match_ff;
      stat.free_found  = free_found_ff;
      stat.lo_valid    = lo_v_ff;
      stat.spread      = lo_ff != hi_ff
                         && (LOAD_W+1)'(maxv_ff) > (LOAD_W+1)'(minv_ff) + (LOAD_W+1)'(1);
      stat.seg_found   = seg_found_ff;
      stat.cap         = int'(n_ff) >= MAX_CHANGES;
      stat.rel_hit     = released_ff[scnt_ff] && owner_ff[scnt_ff] == '0;
   end

   always_comb begin
      wcnt_in = wcnt_ff;
      if (cmd.w_clr) wcnt_in = '0;
      else if (cmd.w_step) wcnt_in = wcnt_ff + WCNT_W'(1);
      scnt_in = scnt_ff;
      priority if (cmd.s_clr_hi) scnt_in = SIDX_W'(SEGMENTS - 1);
      else if (cmd.s_clr_lo) scnt_in = '0;
      else if (cmd.s_down) scnt_in = scnt_ff - SIDX_W'(1);
      else if (cmd.s_up) scnt_in = scnt_ff + SIDX_W'(1);
      else scnt_in = scnt_ff;
      n_in = n_ff;
      if (cmd.load_req) n_in = '0;
      else if (cmd.give1 || cmd.give2 || cmd.do_release) n_in = n_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff    <= SEG_COUNT_RST;
         worker_limit_ff <= WORKER_LIMIT_RST;
         wcnt_ff         <= '0;
         scnt_ff         <= '0;
         n_ff            <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_SEG_COUNT) seg_count_ff <= csr_data[SEG_W-1:0];
         if (csr_we && csr_index == CSR_WORKER_LIMIT) worker_limit_ff <= csr_data;
         wcnt_ff <= wcnt_in;
         scnt_ff <= scnt_in;
         n_ff    <= n_in;
         if (emit) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff <= req_type;
         addr_ff     <= worker_addr;
         slot_ff     <= worker_slot;
         segn_ff     <= segment_number;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_add) addr_mem[free_idx_ff] <= addr_ff;
      if (cmd.add_scan && in_scan_w) rd_ff <= addr_mem[widx];
      rd_idx_ff <= widx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff     <= 1'b0;
         match_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         stat_slot_ff  <= '0;
         lo_v_ff       <= 1'b0;
         seg_found_ff  <= 1'b0;
         for (int s = 0; s < SEGMENTS; s++) begin
            owner_ff[s]    <= '0;
            done_ff[s]     <= 1'b0;
            released_ff[s] <= 1'b0;
         end
         for (int w = 0; w < WORKERS; w++) begin
            active_ff[w] <= 1'b0;
            load_ff[w]   <= '0;
         end
      end else begin
         rd_vld_ff <= cmd.add_scan && in_scan_w;
         if (cmd.load_req) begin
            match_ff      <= 1'b0;
            free_found_ff <= 1'b0;
            stat_slot_ff  <= '0;
         end
         if (cmd.add_scan) begin
            if (rd_vld_ff && !match_ff && active_ff[rd_idx_ff] && rd_ff == addr_ff) begin
               match_ff     <= 1'b1;
               stat_slot_ff <= SLOT_W'(rd_idx_ff) + SLOT_W'(1);
            end
            if (in_scan_w && !free_found_ff && !active_ff[widx]
                && int'(wcnt_ff) < int'(worker_limit_ff)) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= widx;
            end
         end
         if (cmd.do_add) begin
            active_ff[free_idx_ff] <= 1'b1;
            load_ff[free_idx_ff]   <= '0;
            stat_slot_ff           <= SLOT_W'(free_idx_ff) + SLOT_W'(1);
         end
         if (cmd.do_remove) begin
            active_ff[slot_idx] <= 1'b0;
            load_ff[slot_idx]   <= '0;
            for (int s = 0; s < SEGMENTS; s++) begin
               released_ff[s] <= owner_ff[s] == slot_ff;
               if (owner_ff[s] == slot_ff) owner_ff[s] <= '0;
            end
         end
         if (cmd.do_solved) begin
            owner_ff[segn_idx] <= '0;
            done_ff[segn_idx]  <= 1'b1;
            load_ff[slot_idx]  <= load_ff[slot_idx] - LOAD_W'(1);
         end
         if (cmd.w_clr) lo_v_ff <= 1'b0;
         else if (cmd.lh_scan && active_ff[widx]) begin
            lo_v_ff <= 1'b1;
            if (!lo_v_ff || load_ff[widx] < minv_ff) begin
               lo_ff   <= widx;
               minv_ff <= load_ff[widx];
            end
            if (!lo_v_ff || load_ff[widx] > maxv_ff) begin
               hi_ff   <= widx;
               maxv_ff <= load_ff[widx];
            end
         end
         if (cmd.s_clr_hi) seg_found_ff <= 1'b0;
         else if (!seg_found_ff) begin
            if ((cmd.seg_scan1 && int'(scnt_ff) < int'(seg_count_ff)
                 && owner_ff[scnt_ff] == '0 && !done_ff[scnt_ff])
                || (cmd.seg_scan2 && owner_ff[scnt_ff] == hi_slot)) begin
               seg_found_ff <= 1'b1;
               seg_sel_ff   <= scnt_ff;
            end
         end
         if (cmd.give1 || cmd.give2) begin
            owner_ff[seg_sel_ff] <= lo_slot;
            load_ff[lo_ff]       <= minv_ff + LOAD_W'(1);
            if (cmd.give2) load_ff[hi_ff] <= maxv_ff - LOAD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.give1 || cmd.give2) begin
         kind_ff  <= KIND_CHANGE;
         code_ff  <= ST_OK;
         oslot_ff <= lo_slot;
         oseg_ff  <= SEG_W'(seg_sel_ff) + SEG_W'(1);
         last_ff  <= 1'b0;
      end else if (cmd.do_release) begin
         kind_ff  <= KIND_CHANGE;
         code_ff  <= ST_OK;
         oslot_ff <= '0;
         oseg_ff  <= SEG_W'(scnt_ff) + SEG_W'(1);
         last_ff  <= 1'b0;
      end else if (cmd.emit_status) begin
         kind_ff  <= KIND_STATUS;
         code_ff  <= cmd.code;
         oslot_ff <= (cmd.code == ST_OK) ? stat_slot_ff : '0;
         oseg_ff  <= '0;
         last_ff  <= 1'b1;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign item_kind   = kind_ff;
   assign status_code = code_ff;
   assign slot_out    = oslot_ff;
   assign segment_out = oseg_ff;
   assign last_item   = last_ff;

endmodule
